// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL top.
// All three forms take a label, the clock, the active-low reset and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds on every rising clock edge outside reset
`define BAI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in this cycle implies consequent in the same cycle
`define BAI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent in this cycle implies consequent in the next cycle
`define BAI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BAI_ASSERT(lbl, clk, rst_n, prop, msg)
`define BAI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BAI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/bai_pkg.sv =====
package bai_pkg;

    // field widths
    localparam int MODE_W = 3;
    localparam int IDX_W  = 5;
    localparam int RIDX_W = 4;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    // packed stream widths, rounded up to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

// ===== rtl/bounded_array_insert_remove_top.sv =====
// Fixed-capacity ordered list of signed 32-bit words with an occupancy count.
// Input channel s_*: one item per operation (append, insert, remove, read,
// write, reverse range). Result channel m_*: one item per input item with
// the read word, a status code, the count after the operation and an empty flag.
// The words live in a simple dual-port store (one write, one registered read
// per cycle); one shared step/compare unit walks a pointer under a sequencer.
// Rejected or unused operations go straight to the result; append and write
// do one store write, read does one registered store read, remove and insert
// shift one word per move (moves = words shifted, up to DEPTH-1; insert then
// writes the new word), and reverse swaps pairs inward (up to DEPTH/2 pairs).
// The store port paces insert, remove and reverse. Only one item is in work
// at a time; s_tready is low until the result is loaded into the output
// register and rises on the next cycle, so the input is held off for the
// whole of an item's work.
// Reset clears the count and the control state; the store is not cleared,
// and only positions below the count can be seen.
// A stalled receiver holds the result in the output register; the block can
// take and work the next item, then waits before delivering its result.
module bounded_array_insert_remove_top #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mode[2:0], index[7:3], right_index[11:8], value[43:12], zero fill
    input  logic [bai_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value[31:0], status[33:32], count[38:34], is_empty[39]
    output logic [bai_pkg::M_TDATA_W-1:0]   m_tdata
);
    import bai_pkg::*;

`include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_WR   = 11'b000_0000_0010,
        S_RD_A = 11'b000_0000_0100,
        S_RD_B = 11'b000_0000_1000,
        S_MV_A = 11'b000_0001_0000,
        S_MV_B = 11'b000_0010_0000,
        S_RV_A = 11'b000_0100_0000,
        S_RV_B = 11'b000_1000_0000,
        S_RV_C = 11'b001_0000_0000,
        S_RV_D = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } state_t;

    // input fields
    logic [MODE_W-1:0] in_mode;
    logic [IDX_W-1:0]  in_index;
    logic [RIDX_W-1:0] in_ridx;
    logic [DATA_W-1:0] in_value;

    assign in_mode  = s_tdata[2:0];
    assign in_index = s_tdata[7:3];
    assign in_ridx  = s_tdata[11:8];
    assign in_value = s_tdata[43:12];

    // control and work registers
    state_t              state_reg, state_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0]   rd_reg, rd_next;
    logic [DATA_W-1:0]   tmp_reg, tmp_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       lim_reg, lim_next;
    logic [CW-1:0]       hi_reg, hi_next;

    // store port
    logic                mem_we;
    logic [CW-1:0]       wr_addr_full;
    logic [CW-1:0]       rd_addr_full;
    logic [DATA_W-1:0]   mem_wdata;
    logic [DATA_W-1:0]   mem_rdata;

    // shared step and compare unit
    logic                step_up;
    logic [CW-1:0]       ptr_step;
    logic [CW-1:0]       cmp_a, cmp_b;
    logic                cmp_lt;

    // range checks at accept
    logic [XW-1:0]       idx_x, ridx_x, occ_x;
    logic [STAT_W-1:0]   acc_status;
    logic                is_ins;
    logic                load_out;
    logic [CW-1:0]       occ_new;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign ptr_step = step_up ? (ptr_reg + CW'(1)) : (ptr_reg - CW'(1));
    assign cmp_lt   = (cmp_a < cmp_b);
    assign is_ins   = (mode_reg == MODE_INSERT);

    bai_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (wr_addr_full[AW-1:0]),
        .wdata (mem_wdata),
        .raddr (rd_addr_full[AW-1:0]),
        .rdata (mem_rdata)
    );

    // status of a new item from the current count
    always_comb begin
        idx_x  = XW'(in_index);
        ridx_x = XW'(in_ridx);
        occ_x  = XW'(occ_reg);
        acc_status = STAT_OK;
        unique case (in_mode)
            MODE_APPEND: begin
                if (occ_reg == CW'(DEPTH)) acc_status = STAT_FULL;
            end
            MODE_INSERT: begin
                if (idx_x > occ_x) begin
                    acc_status = STAT_RANGE;
                end else if (occ_reg == CW'(DEPTH)) begin
                    acc_status = STAT_FULL;
                end
            end
            MODE_REMOVE, MODE_READ, MODE_WRITE: begin
                if (idx_x >= occ_x) acc_status = STAT_RANGE;
            end
            MODE_REVERSE: begin
                if ((idx_x >= occ_x) || (ridx_x >= occ_x)) acc_status = STAT_RANGE;
            end
            default: acc_status = STAT_OK;
        endcase
    end

    // count after the item in work
    always_comb begin
        occ_new = occ_reg;
        if (status_reg == STAT_OK) begin
            if ((mode_reg == MODE_APPEND) || (mode_reg == MODE_INSERT)) begin
                occ_new = occ_reg + CW'(1);
            end else if (mode_reg == MODE_REMOVE) begin
                occ_new = occ_reg - CW'(1);
            end
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mode_next    = mode_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        rd_next      = rd_reg;
        tmp_next     = tmp_reg;
        ptr_next     = ptr_reg;
        lim_next     = lim_reg;
        hi_next      = hi_reg;
        mem_we       = 1'b0;
        wr_addr_full = ptr_reg;
        rd_addr_full = ptr_reg;
        mem_wdata    = val_reg;
        step_up      = 1'b1;
        cmp_a        = ptr_reg;
        cmp_b        = hi_reg;
        load_out     = 1'b0;

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next   = in_mode;
                    val_next    = in_value;
                    status_next = acc_status;
                    rd_next     = '0;
                    ptr_next    = CW'(in_index);
                    lim_next    = occ_reg;
                    hi_next     = CW'(in_ridx);
                    if (acc_status != STAT_OK) begin
                        state_next = S_DONE;
                    end else begin
                        unique case (in_mode)
                            MODE_APPEND: begin
                                ptr_next   = occ_reg;
                                state_next = S_WR;
                            end
                            MODE_INSERT: begin
                                ptr_next   = occ_reg;
                                lim_next   = CW'(in_index);
                                state_next = S_MV_A;
                            end
                            MODE_REMOVE:  state_next = S_MV_A;
                            MODE_READ:    state_next = S_RD_A;
                            MODE_WRITE:   state_next = S_WR;
                            MODE_REVERSE: state_next = S_RV_A;
                            default:      state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_WR: begin
                mem_we     = 1'b1;
                state_next = S_DONE;
            end
            S_RD_A: begin
                state_next = S_RD_B;
            end
            S_RD_B: begin
                rd_next    = mem_rdata;
                state_next = S_DONE;
            end
            // shift: insert walks down from the count, remove walks up
            S_MV_A: begin
                step_up = !is_ins;
                if (is_ins) begin
                    cmp_a = lim_reg;
                    cmp_b = ptr_reg;
                end else begin
                    cmp_a = ptr_step;
                    cmp_b = lim_reg;
                end
                rd_addr_full = ptr_step;
                if (cmp_lt) begin
                    state_next = S_MV_B;
                end else if (is_ins) begin
                    state_next = S_WR;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MV_B: begin
                step_up    = !is_ins;
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                ptr_next   = ptr_step;
                state_next = S_MV_A;
            end
            // reverse: read low, read high, write both, move inward
            S_RV_A: begin
                if (cmp_lt) begin
                    state_next = S_RV_B;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RV_B: begin
                tmp_next     = mem_rdata;
                rd_addr_full = hi_reg;
                state_next   = S_RV_C;
            end
            S_RV_C: begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                state_next = S_RV_D;
            end
            S_RV_D: begin
                mem_we       = 1'b1;
                wr_addr_full = hi_reg;
                mem_wdata    = tmp_reg;
                ptr_next     = ptr_step;
                hi_next      = hi_reg - CW'(1);
                state_next   = S_RV_A;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    m_data_next  = {(occ_new == '0), CNT_W'(occ_new), status_reg, rd_reg};
                    occ_next     = occ_new;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        mode_reg   <= mode_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        tmp_reg    <= tmp_next;
        ptr_reg    <= ptr_next;
        lim_reg    <= lim_next;
        hi_reg     <= hi_next;
    end

    // checks
    `BAI_ASSERT(a_occ_bound, aclk, aresetn, occ_reg <= CW'(DEPTH), "count above capacity")
    `BAI_ASSERT_IMP(a_wr_in_range, aclk, aresetn, mem_we, wr_addr_full < CW'(DEPTH), "store write out of range")
    `BAI_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "item taken while busy")
    `BAI_ASSERT_IMP(a_err_keeps_count, aclk, aresetn, load_out && (status_reg != STAT_OK), occ_new == occ_reg, "rejected item changed count")
    `BAI_ASSERT_NEXT(a_count_on_load, aclk, aresetn, !load_out, occ_reg == $past(occ_reg), "count changed without a result")

endmodule

// ===== rtl/bai_store.sv =====
module bai_store #(
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [$clog2(DEPTH)-1:0]            waddr,
    input  logic [bai_pkg::DATA_W-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]            raddr,
    output logic [bai_pkg::DATA_W-1:0]          rdata
);
    import bai_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
